/* hw/rtl/bbr_pkg.sv */
// Shared types, constants and helpers for the 3x3 RGBA box blur.
package bbr_pkg;

  localparam int CFG_W         = 11;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_RESET_DIM = 1024;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 1'b1;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // nine 8-bit samples need 12 bits
  localparam int SUM_W = 12;

  // floor(s / 9) == (s * 7282) >> 16 for every s below 2296
  localparam int                RECIP_W    = 13;
  localparam logic [RECIP_W-1:0] DIV9_RECIP = 13'd7282;
  localparam int                DIV9_SHIFT = 16;
  localparam int                PROD_W     = SUM_W + RECIP_W;

  typedef struct packed {
    logic       kind;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic       frame_last;
  } out_item_t;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pix_t;

  // one line-store word: the column's middle-row and upper-row pixels
  typedef struct packed {
    pix_t mid;
    pix_t top;
  } line_word_t;

  typedef struct packed {
    logic has_out;
    logic col_lo_ok;
    logic col_hi_ok;
    logic row_lo_ok;
    logic row_hi_ok;
    logic last;
  } tap_ctl_t;

  typedef struct packed {
    logic [SUM_W-1:0] red_sum;
    logic [SUM_W-1:0] green_sum;
    logic [SUM_W-1:0] blue_sum;
    logic [7:0]       alpha;
    logic             last;
  } blur_sum_t;

  function automatic logic [7:0] div9(input logic [SUM_W-1:0] s);
    logic [PROD_W-1:0] p;
    p = PROD_W'(s) * PROD_W'(DIV9_RECIP);
    return p[DIV9_SHIFT +: 8];
  endfunction

endpackage

/* hw/rtl/box_blur_3x3_rgba.sv */
// 3x3 box blur over a raster RGBA stream: top level with output stage.
//
// Input requests carry one pixel (kind = pixel) or a flush tick (kind = flush)
// and are taken when in_valid is high and in_stall low. Results leave on the
// out_ channel under the same valid/stall rule. The output for a pixel comes
// out once the stream has moved image_width + 1 positions past it; after the
// last pixel of a frame, image_width + 1 flush requests drain the remaining
// outputs, and frame_last marks the frame's final output. Flush requests
// during pixel intake are taken and dropped; pixels during the drain count
// as flush ticks.
// Throughput is one request per cycle while the output is not stalled. out_valid
// rises after the request that completes a result is taken: line-store read at the taking edge,
// then window shift, channel sum, and divide by nine into the output register.
// The line store is one RAM word per column holding the upper and middle rows,
// read and written back once per pixel or drain request; a column revisited on the next
// cycle (single-pixel rows) takes the forwarded value.
// Reset clears the pipeline and the position and sets both dimensions to 1024
// (clamped to the maximum). A stall on the output holds the whole pipeline and
// raises in_stall in the same cycle. cfg_ready is always high; a geometry write
// restarts the frame and must come while the block is idle.
module box_blur_3x3_rgba #(
  parameter int MAX_WIDTH  = bbr_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bbr_pkg::DEF_MAX_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  bbr_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output bbr_pkg::out_item_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bbr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bbr_pkg::CFG_W-1:0]     cfg_data
);

  localparam int COL_W = $clog2(MAX_WIDTH);

  logic                  adv, take, act, drain, load;
  logic [COL_W-1:0]      col;
  bbr_pkg::tap_ctl_t     ctl;
  bbr_pkg::pix_t         bottom;
  logic                  sum_valid;
  bbr_pkg::blur_sum_t    sum;
  logic                  out_valid_r;
  bbr_pkg::out_item_t    out_data_r;

  assign adv       = !(out_valid_r && out_stall);
  assign in_stall  = !adv;
  assign take      = in_valid && adv;
  assign load      = take && act;
  assign cfg_ready = 1'b1;

  bbr_pos #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_pos (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .kind      (in_data.kind),
    .act       (act),
    .drain     (drain),
    .col       (col),
    .ctl       (ctl)
  );

  // drop the samples of a drain request
  always_comb begin
    if (drain) begin
      bottom = '0;
    end else begin
      bottom.red   = in_data.red_in;
      bottom.green = in_data.green_in;
      bottom.blue  = in_data.blue_in;
      bottom.alpha = in_data.alpha_in;
    end
  end

  bbr_window #(
    .DEPTH (MAX_WIDTH)
  ) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .load      (load),
    .addr      (col),
    .bottom    (bottom),
    .ctl       (ctl),
    .sum_valid (sum_valid),
    .sum       (sum)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= sum_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && sum_valid) begin
      out_data_r.red_out    <= bbr_pkg::div9(sum.red_sum);
      out_data_r.green_out  <= bbr_pkg::div9(sum.green_sum);
      out_data_r.blue_out   <= bbr_pkg::div9(sum.blue_sum);
      out_data_r.alpha_out  <= sum.alpha;
      out_data_r.frame_last <= sum.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* hw/rtl/bbr_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module bbr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/bbr_pos.sv */
// Frame geometry registers and raster position tracking with window tap control.
module bbr_pos #(
  parameter int MAX_WIDTH  = bbr_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bbr_pkg::DEF_MAX_HEIGHT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bbr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bbr_pkg::CFG_W-1:0]      cfg_data,
  input  logic                           take,
  input  logic                           kind,
  output logic                           act,
  output logic                           drain,
  output logic [$clog2(MAX_WIDTH)-1:0]   col,
  output bbr_pkg::tap_ctl_t              ctl
);

  localparam int CW    = bbr_pkg::CFG_W;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT + 2);
  localparam int MAX_A = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int MAX_B = (MAX_A > CW) ? MAX_A : CW;
  localparam int EXT_W = MAX_B + 1;
  localparam int RST_WV = (bbr_pkg::CFG_RESET_DIM < MAX_WIDTH) ?
                          bbr_pkg::CFG_RESET_DIM : MAX_WIDTH;
  localparam int RST_HV = (bbr_pkg::CFG_RESET_DIM < MAX_HEIGHT) ?
                          bbr_pkg::CFG_RESET_DIM : MAX_HEIGHT;

  logic [CW-1:0]    width_r, width_nxt;
  logic [CW-1:0]    height_r, height_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;

  logic [CW-1:0]    cfg_dim, width_clamped, height_clamped;
  logic [EXT_W-1:0] c_e, r_e, w_e, h_e, col_inc, cc, cr;

  always_comb begin
    cfg_dim        = (cfg_data == '0) ? CW'(1) : cfg_data;
    width_clamped  = (EXT_W'(cfg_dim) > EXT_W'(MAX_WIDTH))  ? CW'(MAX_WIDTH)  : cfg_dim;
    height_clamped = (EXT_W'(cfg_dim) > EXT_W'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT) : cfg_dim;
  end

  always_comb begin
    c_e     = EXT_W'(col_r);
    r_e     = EXT_W'(row_r);
    w_e     = EXT_W'(width_r);
    h_e     = EXT_W'(height_r);
    col_inc = c_e + EXT_W'(1);

    // centre of the window trails the intake position by one row and one column
    if (c_e != '0) begin
      cc = c_e - EXT_W'(1);
      cr = r_e - EXT_W'(1);
    end else begin
      cc = w_e - EXT_W'(1);
      cr = r_e - EXT_W'(2);
    end

    drain = r_e >= h_e;
    act   = drain || (kind == bbr_pkg::KIND_PIXEL);

    ctl.has_out   = (r_e >= EXT_W'(2)) || ((r_e == EXT_W'(1)) && (c_e != '0));
    ctl.col_lo_ok = cc != '0;
    ctl.col_hi_ok = (cc + EXT_W'(1)) < w_e;
    ctl.row_lo_ok = cr != '0;
    ctl.row_hi_ok = (cr + EXT_W'(1)) < h_e;
    ctl.last      = ctl.has_out && (cc == w_e - EXT_W'(1)) && (cr == h_e - EXT_W'(1));

    col = col_r;
  end

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    if (cfg_we) begin
      // a geometry write restarts the frame
      case (cfg_index)
        bbr_pkg::CFG_IDX_WIDTH: begin
          width_nxt = width_clamped;
          col_nxt   = '0;
          row_nxt   = '0;
        end
        bbr_pkg::CFG_IDX_HEIGHT: begin
          height_nxt = height_clamped;
          col_nxt    = '0;
          row_nxt    = '0;
        end
        default: begin
        end
      endcase
    end else if (take && act) begin
      if (ctl.last) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (col_inc >= w_e) begin
        col_nxt = '0;
        row_nxt = row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CW'(RST_WV);
      height_r <= CW'(RST_HV);
      col_r    <= '0;
      row_r    <= '0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
    end
  end

endmodule

/* hw/rtl/bbr_window.sv */
// Line-store read-modify-write, 3x3 window shift and masked channel sums.
module bbr_window #(
  parameter int DEPTH = bbr_pkg::DEF_MAX_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic                     load,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  bbr_pkg::pix_t            bottom,
  input  bbr_pkg::tap_ctl_t        ctl,
  output logic                     sum_valid,
  output bbr_pkg::blur_sum_t       sum
);

  localparam int AW = $clog2(DEPTH);
  localparam int SW = bbr_pkg::SUM_W;

  logic                  s1_valid_r;
  logic [AW-1:0]         s1_addr_r;
  bbr_pkg::pix_t         s1_bottom_r;
  bbr_pkg::tap_ctl_t     s1_ctl_r;
  logic                  fwd_r;
  bbr_pkg::pix_t         fwd_top_r, fwd_mid_r;
  bbr_pkg::line_word_t   rd_word, wr_word;
  bbr_pkg::pix_t         top_eff, mid_eff;
  bbr_pkg::pix_t         win_r [3][3];   // [column][row], column 2 newest
  logic                  s2_valid_r;
  bbr_pkg::tap_ctl_t     s2_ctl_r;
  logic                  sum_valid_r;
  bbr_pkg::blur_sum_t    sum_r, sum_nxt;
  logic [2:0]            col_ok, row_ok;

  bbr_ram #(
    .WIDTH ($bits(bbr_pkg::line_word_t)),
    .DEPTH (DEPTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_valid_r && adv),
    .waddr (s1_addr_r),
    .wdata (wr_word),
    .re    (load),
    .raddr (addr),
    .rdata (rd_word)
  );

  // take the previous request's write when it hit the same column in the read cycle
  always_comb begin
    top_eff     = fwd_r ? fwd_top_r : rd_word.top;
    mid_eff     = fwd_r ? fwd_mid_r : rd_word.mid;
    wr_word.top = mid_eff;
    wr_word.mid = s1_bottom_r;
  end

  always_comb begin
    col_ok = {s2_ctl_r.col_hi_ok, 1'b1, s2_ctl_r.col_lo_ok};
    row_ok = {s2_ctl_r.row_hi_ok, 1'b1, s2_ctl_r.row_lo_ok};
    sum_nxt.red_sum   = '0;
    sum_nxt.green_sum = '0;
    sum_nxt.blue_sum  = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (col_ok[i] && row_ok[j]) begin
          sum_nxt.red_sum   = sum_nxt.red_sum   + SW'(win_r[i][j].red);
          sum_nxt.green_sum = sum_nxt.green_sum + SW'(win_r[i][j].green);
          sum_nxt.blue_sum  = sum_nxt.blue_sum  + SW'(win_r[i][j].blue);
        end
      end
    end
    sum_nxt.alpha = win_r[1][1].alpha;
    sum_nxt.last  = s2_ctl_r.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_r       <= 1'b0;
      s2_valid_r  <= 1'b0;
      sum_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= load;
      fwd_r       <= load && s1_valid_r && (s1_addr_r == addr);
      s2_valid_r  <= s1_valid_r && s1_ctl_r.has_out;
      sum_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (load) begin
        s1_addr_r   <= addr;
        s1_bottom_r <= bottom;
        s1_ctl_r    <= ctl;
        fwd_top_r   <= mid_eff;
        fwd_mid_r   <= s1_bottom_r;
      end
      if (s1_valid_r) begin
        for (int j = 0; j < 3; j++) begin
          win_r[0][j] <= win_r[1][j];
          win_r[1][j] <= win_r[2][j];
        end
        win_r[2][0] <= top_eff;
        win_r[2][1] <= mid_eff;
        win_r[2][2] <= s1_bottom_r;
        s2_ctl_r    <= s1_ctl_r;
      end
      sum_r <= sum_nxt;
    end
  end

  assign sum_valid = sum_valid_r;
  assign sum       = sum_r;

endmodule

/* test/testbench.sv */
// Self-checking testbench for the 3x3 RGBA box blur: predictor, stimulus and result checks.
import bbr_pkg::*;

class blur_board;
  pix_t        upper_line [DEF_MAX_WIDTH];
  pix_t        middle_line [DEF_MAX_WIDTH];
  pix_t        win [3][3];  // [column][row], column 2 newest
  int unsigned col, row, emitted, width, height;
  out_item_t   blurred_due [$];
  int unsigned failures, requests_seen, results_seen, frames_seen, writes_seen;

  function new();
    foreach (upper_line[i]) begin
      upper_line[i]  = '0;
      middle_line[i] = '0;
    end
    foreach (win[i, j]) win[i][j] = '0;
    col    = 0;
    row    = 0;
    emitted = 0;
    width  = CFG_RESET_DIM;
    height = CFG_RESET_DIM;
  endfunction

  function int unsigned clamp_dim(logic [CFG_W-1:0] v, int unsigned limit);
    if (v == 0) return 1;
    if (v > limit) return limit;
    return v;
  endfunction

  // a geometry write restarts the frame
  function void set_geometry(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
    if (idx == CFG_IDX_WIDTH) width = clamp_dim(v, DEF_MAX_WIDTH);
    else height = clamp_dim(v, DEF_MAX_HEIGHT);
    col     = 0;
    row     = 0;
    emitted = 0;
    writes_seen++;
  endfunction

  function void take_request(in_item_t req);
    pix_t        bot, top, mid;
    int unsigned c, r, area, cr, cc, rs, gs, bs;
    bit          draining;
    bit          colok [3];
    bit          rowok [3];
    out_item_t   res;
    requests_seen++;
    area     = width * height;
    draining = row >= height;
    // drop flush ticks while pixels are still coming in
    if (!draining && req.kind == KIND_FLUSH) return;
    bot = '0;
    if (!draining) begin
      bot.red   = req.red_in;
      bot.green = req.green_in;
      bot.blue  = req.blue_in;
      bot.alpha = req.alpha_in;
    end
    c   = col;
    r   = row;
    top = upper_line[c];
    mid = middle_line[c];
    upper_line[c]  = mid;
    middle_line[c] = bot;
    for (int j = 0; j < 3; j++) begin
      win[0][j] = win[1][j];
      win[1][j] = win[2][j];
    end
    win[2][0] = top;
    win[2][1] = mid;
    win[2][2] = bot;
    col++;
    if (col >= width) begin
      col = 0;
      row++;
    end
    if (!(r >= 2 || (r == 1 && c >= 1))) return;
    if (emitted >= area) return;
    if (c >= 1) begin
      cr = r - 1;
      cc = c - 1;
    end else begin
      cr = r - 2;
      cc = width - 1;
    end
    colok[0] = cc >= 1;
    colok[1] = 1'b1;
    colok[2] = cc + 1 < width;
    rowok[0] = cr >= 1;
    rowok[1] = 1'b1;
    rowok[2] = cr + 1 < height;
    rs = 0;
    gs = 0;
    bs = 0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (colok[i] && rowok[j]) begin
          rs += win[i][j].red;
          gs += win[i][j].green;
          bs += win[i][j].blue;
        end
      end
    end
    res.red_out   = 8'(rs / 9);
    res.green_out = 8'(gs / 9);
    res.blue_out  = 8'(bs / 9);
    res.alpha_out = win[1][1].alpha;
    emitted++;
    res.frame_last = emitted == area;
    if (res.frame_last) begin
      col     = 0;
      row     = 0;
      emitted = 0;
      frames_seen++;
    end
    blurred_due.insert(blurred_due.size(), res);
  endfunction

  function void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endfunction

  function void check_result(out_item_t got);
    out_item_t want;
    results_seen++;
    if (blurred_due.size() == 0) begin
      $error("result with nothing pending: %h", got);
      failures++;
      return;
    end
    want = blurred_due.pop_front();
    compare_field("red_out", want.red_out, got.red_out);
    compare_field("green_out", want.green_out, got.green_out);
    compare_field("blue_out", want.blue_out, got.blue_out);
    compare_field("alpha_out", want.alpha_out, got.alpha_out);
    compare_field("frame_last", 8'(want.frame_last), 8'(got.frame_last));
  endfunction
endclass

module testbench;
  localparam int SETTLE_CYCLES = 12;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int ITEM_TARGET   = 1300;
  localparam int CLAMP_DRAIN   = 4;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  logic        hold_quiet = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned stim_count = 0;
  blur_board   sb;

  box_blur_3x3_rgba dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // random back-pressure, with a long stretch of none
  always @(posedge clk) begin
    if (!rst_n || hold_quiet || (sb.results_seen >= 40 && sb.results_seen < 140))
      out_stall <= 1'b0;
    else
      out_stall <= $urandom_range(99) < 8;
  end

  // sample mid-cycle: the result is taken at the coming rising edge
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout with %0d results pending", sb.blurred_due.size());
      $display("box_blur_3x3_rgba: mismatch");
      $finish;
    end
  end

  function automatic logic [7:0] rand_sample();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    sb.set_geometry(idx, v);
    // idle the channel between writes
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic push_req(input logic kind, input logic [7:0] r, g, b, a);
    in_item_t req;
    req.kind     = kind;
    req.red_in   = r;
    req.green_in = g;
    req.blue_in  = b;
    req.alpha_in = a;
    if (!(sb.requests_seen >= 400 && sb.requests_seen < 800) &&
        $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    sb.take_request(req);
    stim_count++;
  endtask

  task automatic send_random(input logic kind);
    push_req(kind, rand_sample(), rand_sample(), rand_sample(), rand_sample());
  endtask

  // wait out every pending result, then hold off back-pressure while the pipe clears
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.blurred_due.size() != 0) @(posedge clk);
    hold_quiet <= 1'b1;
    repeat (SETTLE_CYCLES) @(posedge clk);
    hold_quiet <= 1'b0;
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] w_reg, h_reg, input int frames,
                           input bit noisy, input bit cut_short);
    int unsigned area, drain, stop_at;
    write_reg(CFG_IDX_WIDTH, w_reg);
    write_reg(CFG_IDX_HEIGHT, h_reg);
    area  = sb.width * sb.height;
    drain = sb.width + 1;
    for (int f = 0; f < frames; f++) begin
      // a cut frame is abandoned by the next geometry write
      stop_at = (cut_short && f == frames - 1) ? $urandom_range(area + drain - 1)
                                                : area + drain;
      for (int k = 0; k < stop_at; k++) begin
        if (k < area) begin
          if (noisy && $urandom_range(99) < 6) send_random(KIND_FLUSH);
          send_random(KIND_PIXEL);
        end else begin
          send_random((noisy && $urandom_range(3) == 0) ? KIND_PIXEL : KIND_FLUSH);
        end
      end
    end
    settle();
  endtask

  initial begin
    logic [CFG_W-1:0] w_reg, h_reg;
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // 1x1 from zero registers: ignored flush, lone pixel, pixel in the drain
    write_reg(CFG_IDX_WIDTH, 11'd0);
    write_reg(CFG_IDX_HEIGHT, 11'd0);
    push_req(KIND_FLUSH, 8'h12, 8'h34, 8'h56, 8'h78);
    push_req(KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'hA5);
    push_req(KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    push_req(KIND_FLUSH, 8'h00, 8'h00, 8'h00, 8'h00);
    settle();

    // 3x3 saturated frame: the center reaches the full sum
    write_reg(CFG_IDX_WIDTH, 11'd3);
    write_reg(CFG_IDX_HEIGHT, 11'd3);
    for (int k = 0; k < 9; k++) push_req(KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'(k * 28));
    repeat (4) push_req(KIND_FLUSH, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    settle();

    // 2x2 checkerboard, pixel during the drain
    write_reg(CFG_IDX_WIDTH, 11'd2);
    write_reg(CFG_IDX_HEIGHT, 11'd2);
    for (int k = 0; k < 4; k++) begin
      if (k == 0 || k == 3) push_req(KIND_PIXEL, 8'hFF, 8'h00, 8'hFF, 8'h00);
      else push_req(KIND_PIXEL, 8'h00, 8'hFF, 8'h00, 8'hFF);
    end
    push_req(KIND_FLUSH, 8'hAA, 8'h55, 8'hAA, 8'h55);
    push_req(KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    push_req(KIND_FLUSH, 8'h00, 8'h00, 8'h00, 8'h00);
    settle();

    while (stim_count < ITEM_TARGET - DEF_MAX_WIDTH - CLAMP_DRAIN) begin
      w_reg = ($urandom_range(9) == 0) ? CFG_W'($urandom_range(9, 20))
                                       : CFG_W'($urandom_range(1, 8));
      h_reg = ($urandom_range(9) == 0) ? CFG_W'($urandom_range(7, 10))
                                       : CFG_W'($urandom_range(1, 6));
      if ($urandom_range(15) == 0) w_reg = '0;
      if ($urandom_range(15) == 0) h_reg = '0;
      run_phase(w_reg, h_reg, $urandom_range(1, 2), $urandom_range(99) < 30,
                $urandom_range(99) < 15);
    end

    // width register maximum clamps to the line-store size: the row wraps there
    write_reg(CFG_IDX_WIDTH, 11'h7FF);
    write_reg(CFG_IDX_HEIGHT, 11'd1);
    repeat (DEF_MAX_WIDTH) send_random(KIND_PIXEL);
    repeat (CLAMP_DRAIN) send_random(KIND_FLUSH);
    settle();

    repeat (20) @(posedge clk);
    $display("%0d requests over %0d register writes, %0d frames closed",
             sb.requests_seen, sb.writes_seen, sb.frames_seen);
    $display("%0d blurred pixels compared, %0d field mismatches",
             sb.results_seen, sb.failures);
    if (sb.failures == 0) $display("box_blur_3x3_rgba: match");
    else $display("box_blur_3x3_rgba: mismatch");
    $finish;
  end
endmodule
